### rtl/assert_macros.svh
// Assertion macros shared by the mailbox RTL.
// Each macro expands to one labeled concurrent assertion clocked on clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define IPFM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define IPFM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/ipfm_pkg.sv
// Package for the interprocessor FIFO mailbox: operation codes, register
// bit positions, sizes and the control/status structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ipfm_pkg;

  localparam int WORD_W         = 32;
  localparam int OP_W           = 4;
  localparam int NIB_W          = 4;
  localparam int FIFO_DEPTH_DEF = 16;

  typedef enum logic [OP_W-1:0] {
    OP_SEND        = 4'd0,
    OP_RECV        = 4'd1,
    OP_CTRL_WRITE  = 4'd2,
    OP_STATUS_READ = 4'd3,
    OP_SYNC_WRITE  = 4'd4,
    OP_SYNC_READ   = 4'd5,
    OP_REMOTE_PUSH = 4'd6,
    OP_REMOTE_POP  = 4'd7,
    OP_REMOTE_SYNC = 4'd8
  } op_t;

  // Control/status register bit positions.
  localparam int CS_SEND_EMPTY = 0;
  localparam int CS_SEND_FULL  = 1;
  localparam int CS_SEND_IRQEN = 2;
  localparam int CS_SEND_FLUSH = 3;
  localparam int CS_RECV_EMPTY = 8;
  localparam int CS_RECV_FULL  = 9;
  localparam int CS_RECV_IRQEN = 10;
  localparam int CS_ERROR      = 14;
  localparam int CS_ENABLE     = 15;

  // Sync register bit positions.
  localparam int SY_IN_LSB   = 0;
  localparam int SY_OUT_LSB  = 8;
  localparam int SY_IRQ_REQ  = 13;
  localparam int SY_IRQ_ALOW = 14;

  typedef struct packed {
    logic push;
    logic pop;
    logic flush;
  } fifo_ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

endpackage

`default_nettype wire

### rtl/ipfm_if.sv
// Valid/ready channel interfaces for the mailbox request and response words.
// Depends on ipfm_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface ipfm_in_if;
  logic                         valid;
  logic                         ready;
  logic [ipfm_pkg::OP_W-1:0]    operation;
  logic [ipfm_pkg::WORD_W-1:0]  data;

  modport source (output valid, output operation, output data, input ready);
  modport sink   (input valid, input operation, input data, output ready);
endinterface

interface ipfm_out_if;
  logic                         valid;
  logic                         ready;
  logic [ipfm_pkg::WORD_W-1:0]  read_data;
  logic                         error_flag;
  logic                         remote_sync_irq;
  logic                         local_sync_irq;

  modport source (output valid, output read_data, output error_flag,
                  output remote_sync_irq, output local_sync_irq, input ready);
  modport sink   (input valid, input read_data, input error_flag,
                  input remote_sync_irq, input local_sync_irq, output ready);
endinterface

`default_nettype wire

### rtl/interprocessor_fifo_mailbox.sv
// Local side of a two-processor mailbox: send and receive FIFOs plus sync nibbles.
// Response: the response to a request word is registered at the edge that accepts it.
// Throughput: one request word per cycle while the response side keeps up;
//   each FIFO push or pop is a single registered update of its cell chain.
// Reset (rst_n, synchronous, active low) empties both FIFOs and clears all
//   control, sync and last-read registers; FIFO cell contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module interprocessor_fifo_mailbox #(
  parameter int FIFO_DEPTH = ipfm_pkg::FIFO_DEPTH_DEF
) (
  input  wire        clk,
  input  wire        rst_n,
  ipfm_in_if.sink    in_bus,
  ipfm_out_if.source out_bus
);
  import ipfm_pkg::*;

  // Handshake. The response register frees up as soon as its word is taken,
  // so a new request is accepted in the same cycle the previous one drains.
  logic accept;
  logic out_valid_r;

  assign in_bus.ready = !out_valid_r || out_bus.ready;
  assign accept       = in_bus.valid && in_bus.ready;

  // Architectural registers.
  logic              en_r, en_nxt;
  logic              err_r, err_nxt;
  logic              send_irqen_r, send_irqen_nxt;
  logic              recv_irqen_r, recv_irqen_nxt;
  logic [NIB_W-1:0]  sync_in_r, sync_in_nxt;
  logic [NIB_W-1:0]  sync_out_r, sync_out_nxt;
  logic              local_allow_r, local_allow_nxt;
  logic              remote_allow_r, remote_allow_nxt;
  logic [WORD_W-1:0] send_last_r, send_last_nxt;
  logic [WORD_W-1:0] recv_last_r, recv_last_nxt;

  // Response register.
  logic [WORD_W-1:0] out_rd_r;
  logic              out_err_r;
  logic              out_rirq_r;
  logic              out_lirq_r;

  // Per-access response values.
  logic [WORD_W-1:0] rd;
  logic              rirq;
  logic              lirq;

  // FIFO hookup.
  fifo_ctrl_t        send_ctl, recv_ctl;
  fifo_stat_t        send_st, recv_st;
  logic [WORD_W-1:0] send_head, recv_head;

  ipfm_cell_fifo #(.DEPTH(FIFO_DEPTH)) u_send_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (send_ctl),
    .push_word (in_bus.data),
    .stat      (send_st),
    .head_word (send_head)
  );

  ipfm_cell_fifo #(.DEPTH(FIFO_DEPTH)) u_recv_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (recv_ctl),
    .push_word (in_bus.data),
    .stat      (recv_st),
    .head_word (recv_head)
  );

  // Operation decode. Everything happens in the accept cycle; the response
  // is captured into the output register at the same edge.
  always_comb begin
    en_nxt           = en_r;
    err_nxt          = err_r;
    send_irqen_nxt   = send_irqen_r;
    recv_irqen_nxt   = recv_irqen_r;
    sync_in_nxt      = sync_in_r;
    sync_out_nxt     = sync_out_r;
    local_allow_nxt  = local_allow_r;
    remote_allow_nxt = remote_allow_r;
    send_last_nxt    = send_last_r;
    recv_last_nxt    = recv_last_r;
    send_ctl         = '0;
    recv_ctl         = '0;
    rd               = '0;
    rirq             = 1'b0;
    lirq             = 1'b0;

    if (accept) begin
      unique case (in_bus.operation)
        OP_SEND: begin
          // The full check wins even when the FIFOs are disabled.
          if (send_st.full) begin
            err_nxt = 1'b1;
          end else begin
            send_ctl.push = en_r;
          end
        end
        OP_RECV: begin
          if (recv_st.empty) begin
            err_nxt = 1'b1;
            rd      = recv_last_r;
          end else begin
            // While disabled the head word is returned but left in place.
            rd            = recv_head;
            recv_last_nxt = recv_head;
            recv_ctl.pop  = en_r;
          end
        end
        OP_CTRL_WRITE: begin
          send_irqen_nxt = in_bus.data[CS_SEND_IRQEN];
          recv_irqen_nxt = in_bus.data[CS_RECV_IRQEN];
          en_nxt         = in_bus.data[CS_ENABLE];
          if (in_bus.data[CS_SEND_FLUSH]) begin
            send_ctl.flush = 1'b1;
            send_last_nxt  = '0;
          end
          if (in_bus.data[CS_ERROR]) begin
            err_nxt = 1'b0;
          end
        end
        OP_STATUS_READ: begin
          rd[CS_SEND_EMPTY] = send_st.empty;
          rd[CS_SEND_FULL]  = send_st.full;
          rd[CS_SEND_IRQEN] = send_irqen_r;
          rd[CS_RECV_EMPTY] = recv_st.empty;
          rd[CS_RECV_FULL]  = recv_st.full;
          rd[CS_RECV_IRQEN] = recv_irqen_r;
          rd[CS_ERROR]      = err_r;
          rd[CS_ENABLE]     = en_r;
        end
        OP_SYNC_WRITE: begin
          sync_out_nxt    = in_bus.data[SY_OUT_LSB +: NIB_W];
          local_allow_nxt = in_bus.data[SY_IRQ_ALOW];
          rirq            = in_bus.data[SY_IRQ_REQ] && remote_allow_r;
        end
        OP_SYNC_READ: begin
          rd[SY_IN_LSB +: NIB_W]  = sync_in_r;
          rd[SY_OUT_LSB +: NIB_W] = sync_out_r;
          rd[SY_IRQ_ALOW]         = local_allow_r;
        end
        OP_REMOTE_PUSH: begin
          // The remote side is always enabled; a full FIFO drops the word.
          recv_ctl.push = 1'b1;
        end
        OP_REMOTE_POP: begin
          if (send_st.empty) begin
            rd = send_last_r;
          end else begin
            rd            = send_head;
            send_last_nxt = send_head;
            send_ctl.pop  = 1'b1;
          end
        end
        OP_REMOTE_SYNC: begin
          sync_in_nxt      = in_bus.data[SY_OUT_LSB +: NIB_W];
          remote_allow_nxt = in_bus.data[SY_IRQ_ALOW];
          lirq             = in_bus.data[SY_IRQ_REQ] && local_allow_r;
        end
        default: begin
          // Unused codes do nothing and read back zero.
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r           <= 1'b0;
      err_r          <= 1'b0;
      send_irqen_r   <= 1'b0;
      recv_irqen_r   <= 1'b0;
      sync_in_r      <= '0;
      sync_out_r     <= '0;
      local_allow_r  <= 1'b0;
      remote_allow_r <= 1'b0;
      send_last_r    <= '0;
      recv_last_r    <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      en_r           <= en_nxt;
      err_r          <= err_nxt;
      send_irqen_r   <= send_irqen_nxt;
      recv_irqen_r   <= recv_irqen_nxt;
      sync_in_r      <= sync_in_nxt;
      sync_out_r     <= sync_out_nxt;
      local_allow_r  <= local_allow_nxt;
      remote_allow_r <= remote_allow_nxt;
      send_last_r    <= send_last_nxt;
      recv_last_r    <= recv_last_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Response payload needs no reset; it is qualified by out_valid_r.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_rd_r   <= rd;
      out_err_r  <= err_nxt;
      out_rirq_r <= rirq;
      out_lirq_r <= lirq;
    end
  end

  assign out_bus.valid           = out_valid_r;
  assign out_bus.read_data       = out_rd_r;
  assign out_bus.error_flag      = out_err_r;
  assign out_bus.remote_sync_irq = out_rirq_r;
  assign out_bus.local_sync_irq  = out_lirq_r;

  `IPFM_ASSERT(a_accept_gives_word, accept |=> out_valid_r, "accepted request produced no response")
  `IPFM_ASSERT(a_err_matches, out_valid_r |-> (out_err_r == err_r), "response error flag differs from sticky error")
  `IPFM_ASSERT(a_irq_exclusive, out_valid_r |-> !(out_rirq_r && out_lirq_r), "both sync interrupts raised by one request")

endmodule

`default_nettype wire

### rtl/ipfm_cell.sv
// One storage cell of the shifting FIFO chain: holds a word, loads a pushed
// word or takes its upstream neighbor's word on a pop. Depends on ipfm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ipfm_cell (
  input  wire                          clk,
  input  ipfm_pkg::cell_ctrl_t         ctrl,
  input  wire [ipfm_pkg::WORD_W-1:0]   load_word,
  input  wire [ipfm_pkg::WORD_W-1:0]   next_word,
  output logic [ipfm_pkg::WORD_W-1:0]  word
);
  import ipfm_pkg::*;

  logic [WORD_W-1:0] word_r;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      word_r <= load_word;
    end else if (ctrl.shift) begin
      word_r <= next_word;
    end
  end

  assign word = word_r;

endmodule

`default_nettype wire

### rtl/ipfm_cell_fifo.sv
// FIFO built as a chain of ipfm_cell stages; the head word is always in cell 0.
// Depends on ipfm_pkg, ipfm_cell and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module ipfm_cell_fifo #(
  parameter int DEPTH = ipfm_pkg::FIFO_DEPTH_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  ipfm_pkg::fifo_ctrl_t         ctrl,
  input  wire [ipfm_pkg::WORD_W-1:0]   push_word,
  output ipfm_pkg::fifo_stat_t         stat,
  output logic [ipfm_pkg::WORD_W-1:0]  head_word
);
  import ipfm_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic              do_push;
  logic              do_pop;
  logic [WORD_W-1:0] cell_word [DEPTH];

  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == CNT_W'(DEPTH));
  assign do_push    = ctrl.push && !stat.full;
  assign do_pop     = ctrl.pop && !stat.empty;

  // A pop moves every word one cell toward the head; a push lands in the
  // first free cell, which is the one indexed by the current fill.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_ctrl_t        cc;
    logic [WORD_W-1:0] upstream;

    assign cc.load  = do_push && (count_r == CNT_W'(i));
    assign cc.shift = do_pop;
    if (i == DEPTH - 1) begin : g_tail
      assign upstream = cell_word[i];
    end else begin : g_mid
      assign upstream = cell_word[i+1];
    end

    ipfm_cell u_cell (
      .clk       (clk),
      .ctrl      (cc),
      .load_word (push_word),
      .next_word (upstream),
      .word      (cell_word[i])
    );
  end

  assign head_word = cell_word[0];

  always_comb begin
    count_nxt = count_r;
    if (ctrl.flush) begin
      count_nxt = '0;
    end else if (do_push) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  `IPFM_ASSERT(a_count_bound, count_r <= CNT_W'(DEPTH), "fill count above depth")
  `IPFM_ASSERT(a_flush_empties, ctrl.flush |=> stat.empty, "flush left words behind")
  `IPFM_ASSERT(a_pop_decrements,
    (do_pop && !ctrl.flush && !ctrl.push) |=> (count_r == $past(count_r) - 1'b1),
    "pop did not drop fill by one")

endmodule

`default_nettype wire

### dv/testbench.sv
// Self-checking testbench for interprocessor_fifo_mailbox: drives local and remote
// accesses through ipfm_in_if, checks every response word from ipfm_out_if.
// Depends on rtl/ipfm_pkg.sv, rtl/ipfm_if.sv and the mailbox RTL.
`timescale 1ns / 1ps

module testbench;
  import ipfm_pkg::*;

  localparam int CLK_PERIOD     = 20;
  localparam int DEPTH          = FIFO_DEPTH_DEF;
  localparam int MAX_WAIT       = 15;    // longest gap or stall drawn for one word
  localparam int RANDOM_WORDS   = 400;
  localparam int SETTLE_CYCLES  = 4;
  localparam int WATCHDOG_LIMIT = 1000;  // cycles without any handshake

  // Operation codes past the last defined one; the block must ignore them.
  localparam int OP_UNUSED_LO = int'(OP_REMOTE_SYNC) + 1;
  localparam int OP_UNUSED_HI = (1 << OP_W) - 1;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [WORD_W-1:0] data;
    int unsigned       gap;    // idle cycles after this word is taken
    bit                drain;  // hold this word until every response is back
  } mbox_req_t;

  typedef struct packed {
    logic [WORD_W-1:0] read_data;
    logic              error_flag;
    logic              remote_sync_irq;
    logic              local_sync_irq;
  } mbox_resp_t;

  logic clk = 1'b0;
  logic rst_n;

  ipfm_in_if  in_ch ();
  ipfm_out_if out_ch ();

  interprocessor_fifo_mailbox #(
    .FIFO_DEPTH (DEPTH)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_ch),
    .out_bus (out_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Mailbox shadow state. The send ring carries words from this side to the
  // remote one, the receive ring the other way.
  // ---------------------------------------------------------------------------
  logic [WORD_W-1:0] send_ring [DEPTH];
  logic [WORD_W-1:0] recv_ring [DEPTH];
  int                send_head = 0, send_fill = 0, recv_head = 0, recv_fill = 0;
  logic [WORD_W-1:0] send_last = '0, recv_last = '0;
  logic              mbox_enable = 1'b0, mbox_error = 1'b0;
  logic              send_irq_en = 1'b0, recv_irq_en = 1'b0;
  logic [NIB_W-1:0]  nibble_in = '0, nibble_out = '0;
  logic              local_irq_allow = 1'b0, remote_irq_allow = 1'b0;

  // Statistics for the closing summary.
  int send_overflows = 0, recv_underflows = 0, sync_irqs = 0;
  int send_peak = 0, recv_peak = 0;

  mbox_req_t  pending_words [$];
  mbox_resp_t expected_resp [$];
  int         words_sent = 0, results_taken = 0, mismatches = 0, idle_cycles;
  int         stall_left, gap_left, directed_words;
  bit         send_steady, recv_steady = 1'b0, drain_next;

  // Works out the response to one accepted word and advances the shadow state.
  function automatic mbox_resp_t predict_mailbox_access(logic [OP_W-1:0] op,
                                                        logic [WORD_W-1:0] d);
    mbox_resp_t r;
    r = '0;
    case (op)
      OP_SEND: begin
        // The full check comes first, so an overflow is flagged even while
        // the FIFOs are disabled.
        if (send_fill >= DEPTH) begin
          mbox_error = 1'b1;
          send_overflows++;
        end else if (mbox_enable) begin
          send_ring[(send_head + send_fill) % DEPTH] = d;
          send_fill++;
        end
      end
      OP_RECV: begin
        if (recv_fill == 0) begin
          mbox_error  = 1'b1;
          r.read_data = recv_last;
          recv_underflows++;
        end else begin
          // A disabled receive FIFO shows its head word but keeps it.
          r.read_data = recv_ring[recv_head];
          recv_last   = r.read_data;
          if (mbox_enable) begin
            recv_head = (recv_head + 1) % DEPTH;
            recv_fill--;
          end
        end
      end
      OP_CTRL_WRITE: begin
        send_irq_en = d[CS_SEND_IRQEN];
        if (d[CS_SEND_FLUSH]) begin
          send_head = 0;
          send_fill = 0;
          send_last = '0;
        end
        recv_irq_en = d[CS_RECV_IRQEN];
        if (d[CS_ERROR]) mbox_error = 1'b0;
        mbox_enable = d[CS_ENABLE];
      end
      OP_STATUS_READ: begin
        r.read_data[CS_SEND_EMPTY] = (send_fill == 0);
        r.read_data[CS_SEND_FULL]  = (send_fill >= DEPTH);
        r.read_data[CS_SEND_IRQEN] = send_irq_en;
        r.read_data[CS_RECV_EMPTY] = (recv_fill == 0);
        r.read_data[CS_RECV_FULL]  = (recv_fill >= DEPTH);
        r.read_data[CS_RECV_IRQEN] = recv_irq_en;
        r.read_data[CS_ERROR]      = mbox_error;
        r.read_data[CS_ENABLE]     = mbox_enable;
      end
      OP_SYNC_WRITE: begin
        nibble_out        = d[SY_OUT_LSB +: NIB_W];
        local_irq_allow   = d[SY_IRQ_ALOW];
        r.remote_sync_irq = d[SY_IRQ_REQ] && remote_irq_allow;
      end
      OP_SYNC_READ: begin
        r.read_data[SY_IN_LSB +: NIB_W]  = nibble_in;
        r.read_data[SY_OUT_LSB +: NIB_W] = nibble_out;
        r.read_data[SY_IRQ_ALOW]         = local_irq_allow;
      end
      OP_REMOTE_PUSH: begin
        // The remote side is always enabled and a full FIFO just drops the word.
        if (recv_fill < DEPTH) begin
          recv_ring[(recv_head + recv_fill) % DEPTH] = d;
          recv_fill++;
        end
      end
      OP_REMOTE_POP: begin
        if (send_fill == 0) begin
          r.read_data = send_last;
        end else begin
          r.read_data = send_ring[send_head];
          send_last   = r.read_data;
          send_head   = (send_head + 1) % DEPTH;
          send_fill--;
        end
      end
      OP_REMOTE_SYNC: begin
        nibble_in        = d[SY_OUT_LSB +: NIB_W];
        remote_irq_allow = d[SY_IRQ_ALOW];
        r.local_sync_irq = d[SY_IRQ_REQ] && local_irq_allow;
      end
      default: ;
    endcase
    r.error_flag = mbox_error;
    if (r.remote_sync_irq || r.local_sync_irq) sync_irqs++;
    if (send_fill > send_peak) send_peak = send_fill;
    if (recv_fill > recv_peak) recv_peak = recv_fill;
    return r;
  endfunction

  task automatic check_field(input string field, input logic [WORD_W-1:0] want,
                             input logic [WORD_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%08h, actual 0x%08h", field, want, got);
      mismatches++;
    end
  endtask

  // Appends one word to the stimulus queue. The sender gap is drawn here, so
  // a run of words queued while send_steady is set goes back to back.
  task automatic queue_access(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] d);
    mbox_req_t req;
    req.op    = op;
    req.data  = d;
    req.gap   = send_steady ? 0 : $urandom_range(MAX_WAIT, 0);
    req.drain = drain_next;
    drain_next = 1'b0;
    pending_words.push_back(req);
  endtask

  // ---------------------------------------------------------------------------
  // Driver. A word that is not taken stays on the bus unchanged; after a word
  // is taken the line idles for the gap drawn for it. A word marked for drain
  // is held back until every response issued so far has been collected.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid     <= 1'b0;
      in_ch.operation <= '0;
      in_ch.data      <= '0;
      gap_left        <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) words_sent = words_sent + 1;
      if (in_ch.valid && !in_ch.ready) begin
        // Hold the current word.
      end else if (gap_left != 0) begin
        in_ch.valid <= 1'b0;
        gap_left    <= gap_left - 1;
      end else if (pending_words.size() != 0 &&
                   !(pending_words[0].drain &&
                     words_sent != results_taken + int'(out_ch.valid && out_ch.ready))) begin
        in_ch.valid     <= 1'b1;
        in_ch.operation <= pending_words[0].op;
        in_ch.data      <= pending_words[0].data;
        gap_left        <= pending_words[0].gap;
        void'(pending_words.pop_front());
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Response side backpressure: after each word taken, ready drops for a drawn
  // number of cycles. Steady stretches keep ready high throughout.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else if (out_ch.valid && out_ch.ready) begin
      if ($urandom_range(31, 0) == 0) recv_steady = !recv_steady;
      if (recv_steady) begin
        out_ch.ready <= 1'b1;
      end else begin
        stall_left <= $urandom_range(MAX_WAIT, 0);
        out_ch.ready <= 1'b0;
      end
    end else if (stall_left > 1) begin
      stall_left   <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      stall_left   <= 0;
      out_ch.ready <= 1'b1;
    end
  end

  // Monitor: predicts on every accepted request word, then checks the response
  // word taken at this edge against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        expected_resp.push_back(predict_mailbox_access(in_ch.operation, in_ch.data));
      if (out_ch.valid && out_ch.ready) begin
        results_taken <= results_taken + 1;
        if (expected_resp.size() == 0) begin
          $error("response word with no request outstanding: read_data 0x%08h",
                 out_ch.read_data);
          mismatches++;
        end else begin
          check_field("read_data", expected_resp[0].read_data, out_ch.read_data);
          check_field("error_flag", WORD_W'(expected_resp[0].error_flag),
                      WORD_W'(out_ch.error_flag));
          check_field("remote_sync_irq", WORD_W'(expected_resp[0].remote_sync_irq),
                      WORD_W'(out_ch.remote_sync_irq));
          check_field("local_sync_irq", WORD_W'(expected_resp[0].local_sync_irq),
                      WORD_W'(out_ch.local_sync_irq));
          void'(expected_resp.pop_front());
        end
      end
    end
  end

  // Watchdog: a stuck handshake on either side ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired after %0d idle cycles, %0d responses outstanding",
               idle_cycles, expected_resp.size());
      $display("interprocessor_fifo_mailbox verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [WORD_W-1:0] d;
    logic [OP_W-1:0]   op_code;
    int                n;

    rst_n       = 1'b0;
    send_steady = 1'b0;
    drain_next  = 1'b0;

    // Directed part. Right after reset everything is disabled and empty, so
    // the first accesses hit the empty and disabled paths.
    queue_access(OP_STATUS_READ, '0);
    queue_access(OP_RECV, '0);               // underflow returns the zero last word
    queue_access(OP_REMOTE_POP, '0);         // empty remote pop, no local error
    queue_access(OP_SEND, '1);               // disabled, word not stored
    queue_access(OP_CTRL_WRITE, '1);         // enable, flush, clear error, IRQ enables
    queue_access(OP_STATUS_READ, '0);
    // Sync exchange: both allow bits set, then interrupts requested each way.
    queue_access(OP_SYNC_WRITE, '1);
    queue_access(OP_REMOTE_SYNC, '1);        // raises the local interrupt
    queue_access(OP_SYNC_WRITE, WORD_W'(1) << SY_IRQ_REQ);   // raises the remote one
    queue_access(OP_REMOTE_SYNC, WORD_W'(1) << SY_IRQ_REQ);  // local allow now clear
    queue_access(OP_SYNC_READ, '0);
    // Send path with both data extremes, then a pop past the end.
    queue_access(OP_SEND, '1);
    queue_access(OP_SEND, '0);
    queue_access(OP_REMOTE_POP, '0);
    queue_access(OP_REMOTE_POP, '0);
    queue_access(OP_REMOTE_POP, '0);
    // Receive path; with the FIFOs disabled the head word is shown but kept.
    queue_access(OP_REMOTE_PUSH, 32'hA5A5_5A5A);
    queue_access(OP_REMOTE_PUSH, '0);
    queue_access(OP_CTRL_WRITE, '0);
    queue_access(OP_RECV, '0);
    queue_access(OP_RECV, '0);
    queue_access(OP_SEND, 32'h1234_5678);
    queue_access(OP_REMOTE_POP, '0);
    queue_access(OP_W'(OP_UNUSED_LO), '1);
    queue_access(OP_W'(OP_UNUSED_HI), '1);
    d = '0;
    d[CS_ENABLE]     = 1'b1;
    d[CS_SEND_FLUSH] = 1'b1;
    queue_access(OP_CTRL_WRITE, d);          // flush clears the send last word too
    queue_access(OP_REMOTE_POP, '0);
    queue_access(OP_STATUS_READ, '0);
    directed_words = pending_words.size();

    // Random part, built from short scenarios. Filling runs can push past the
    // depth so the full and overflow paths come up regularly.
    drain_next = 1'b1;
    while (pending_words.size() < directed_words + RANDOM_WORDS) begin
      send_steady = ($urandom_range(3, 0) == 0);
      if (pending_words.size() >= directed_words + RANDOM_WORDS / 2 &&
          pending_words.size() < directed_words + RANDOM_WORDS / 2 + 8)
        drain_next = 1'b1;
      case ($urandom_range(5, 0))
        0: begin
          d = $urandom;
          d[CS_ENABLE] = 1'b1;
          queue_access(OP_CTRL_WRITE, d);
          n = $urandom_range(DEPTH + 4, 4);
          repeat (n) queue_access(OP_SEND, $urandom);
          queue_access(OP_STATUS_READ, $urandom);
          n = $urandom_range(DEPTH + 4, 0);
          repeat (n) queue_access(OP_REMOTE_POP, $urandom);
        end
        1: begin
          n = $urandom_range(DEPTH + 4, 4);
          repeat (n) queue_access(OP_REMOTE_PUSH, $urandom);
          queue_access(OP_STATUS_READ, $urandom);
          n = $urandom_range(DEPTH + 4, 1);
          repeat (n) queue_access(OP_RECV, $urandom);
        end
        2: begin
          // Mostly leaves the FIFOs enabled; flush and error clear are random.
          d = $urandom;
          d[CS_ENABLE] = ($urandom_range(3, 0) != 0);
          queue_access(OP_CTRL_WRITE, d);
          queue_access(OP_STATUS_READ, $urandom);
        end
        3: begin
          queue_access(OP_SYNC_WRITE, $urandom);
          queue_access(OP_REMOTE_SYNC, $urandom);
          queue_access(OP_SYNC_READ, $urandom);
          queue_access(OP_SYNC_WRITE, $urandom);
          queue_access(OP_REMOTE_SYNC, $urandom);
        end
        default: begin
          repeat (8) begin
            if ($urandom_range(15, 0) == 0)
              op_code = OP_W'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
            else
              op_code = OP_W'($urandom_range(int'(OP_REMOTE_SYNC), int'(OP_SEND)));
            queue_access(op_code, $urandom);
          end
        end
      endcase
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Sample on the falling edge so the queues are settled.
    do @(negedge clk);
    while (pending_words.size() != 0 || in_ch.valid || expected_resp.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Ran %0d request words (%0d directed), checked %0d response words.",
             words_sent, directed_words, results_taken);
    $display("Send overflows %0d, receive underflows %0d, sync interrupts %0d, peak fill %0d/%0d.",
             send_overflows, recv_underflows, sync_irqs, send_peak, recv_peak);
    if (mismatches == 0 && expected_resp.size() == 0) begin
      $display("interprocessor_fifo_mailbox verification clean");
    end else begin
      $display("interprocessor_fifo_mailbox verification failed");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/ipfm_pkg.sv
rtl/ipfm_if.sv
rtl/ipfm_cell.sv
rtl/ipfm_cell_fifo.sv
rtl/interprocessor_fifo_mailbox.sv
dv/testbench.sv
